// ===== hdl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the integer to text formatter
// Conversion selector codes, the classified job beat passed from the front
// end to the back end, and ASCII helpers.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int NUM_W       = 64;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 7;
    localparam int DEC_DIGITS  = 20;
    localparam int BCD_W       = 4 * DEC_DIGITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CH_MINUS     = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OF = 7'd55;

    typedef enum logic [OP_W-1:0] {
        OP_SDEC    = 2'd0,
        OP_UDEC    = 2'd1,
        OP_HEX_MAG = 2'd2,
        OP_HEX_16  = 2'd3
    } t_op;

    // Classified conversion job
    typedef struct packed {
        logic             is_dec;   // decimal text, else hex
        logic             neg;      // write a leading minus sign
        logic [3:0]       hex_dm1;  // hex digit count minus one
        logic [NUM_W-1:0] value;    // magnitude for decimal, raw value for hex
    } t_job;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {3'b000, nib};
        return (nib > 4'd9) ? wide + HEX_ALPHA_OF : wide + CH_ZERO;
    endfunction

endpackage

// ===== hdl/itf_front.sv =====
// ----------------------------------------------------------------------------
// itf_front: input classifier
// Decodes the conversion selector, takes the magnitude of negative signed
// values and picks the hex digit count from the value's size.
// ----------------------------------------------------------------------------
module itf_front (
    input  logic [itf_pkg::OP_W-1:0]  i_operation,
    input  logic [itf_pkg::NUM_W-1:0] i_number,
    output itf_pkg::t_job             o_job
);

    logic [itf_pkg::NUM_W-1:0] negated;
    logic [3:0]                mag_dm1;

    assign negated = (~i_number) + {{(itf_pkg::NUM_W-1){1'b0}}, 1'b1};

    always_comb begin
        if (i_number[itf_pkg::NUM_W-1:8] == '0) begin
            mag_dm1 = 4'd1;
        end else if (i_number[itf_pkg::NUM_W-1:16] == '0) begin
            mag_dm1 = 4'd3;
        end else if (i_number[itf_pkg::NUM_W-1:32] == '0) begin
            mag_dm1 = 4'd7;
        end else begin
            mag_dm1 = 4'd15;
        end
    end

    always_comb begin
        o_job.is_dec  = 1'b0;
        o_job.neg     = 1'b0;
        o_job.hex_dm1 = 4'd15;
        o_job.value   = i_number;
        unique case (itf_pkg::t_op'(i_operation))
            itf_pkg::OP_SDEC: begin
                o_job.is_dec = 1'b1;
                o_job.neg    = i_number[itf_pkg::NUM_W-1];
                if (i_number[itf_pkg::NUM_W-1]) begin
                    o_job.value = negated;
                end
            end
            itf_pkg::OP_UDEC: begin
                o_job.is_dec = 1'b1;
            end
            itf_pkg::OP_HEX_MAG: begin
                o_job.hex_dm1 = mag_dm1;
            end
            itf_pkg::OP_HEX_16: begin
                o_job.hex_dm1 = 4'd15;
            end
            default: begin
                o_job.hex_dm1 = 4'd15;
            end
        endcase
    end

endmodule

// ===== hdl/itf_queue.sv =====
// ----------------------------------------------------------------------------
// itf_queue: job queue between front and back end
// Small circular buffer of classified jobs.
// ----------------------------------------------------------------------------
module itf_queue #(
    parameter int DEPTH = itf_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output itf_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    itf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/itf_back.sv =====
// ----------------------------------------------------------------------------
// itf_back: character generator
// Converts a job to text: bit-serial binary to BCD with a leading zero scan
// for decimal, a nibble shifter for hex. A new job is taken only once the last one is done.
// ----------------------------------------------------------------------------
module itf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  itf_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic [itf_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DABBLE,
        S_DEC,
        S_HEX
    } t_state;

    t_state                      r_state, n_state;
    logic [itf_pkg::NUM_W-1:0]   r_bin, n_bin;
    logic [itf_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [5:0]                  r_cnt, n_cnt;
    logic                        r_seen, n_seen;
    logic                        r_strobe, n_strobe;
    logic                        r_last, n_last;
    logic [itf_pkg::CHAR_W-1:0]  r_char, n_char;
    logic [itf_pkg::BCD_W-1:0]   bcd_adj;
    logic [3:0]                  top_digit;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < itf_pkg::DEC_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                r_bcd[4*d +: 4] + 4'd3 : r_bcd[4*d +: 4];
        end
    end

    assign top_digit = r_bcd[itf_pkg::BCD_W-1 -: 4];

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_char   = r_char;
        o_pop    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_bcd = '0;
                    if (i_job.is_dec) begin
                        n_bin   = i_job.value;
                        n_cnt   = 6'd63;
                        n_state = S_DABBLE;
                        if (i_job.neg) begin
                            n_strobe = 1'b1;
                            n_char   = itf_pkg::CH_MINUS;
                        end
                    end else begin
                        // align the first digit to the top nibble
                        n_bin   = i_job.value << {~i_job.hex_dm1, 2'b00};
                        n_cnt   = {2'b00, i_job.hex_dm1};
                        n_state = S_HEX;
                    end
                end
            end
            S_DABBLE: begin
                n_bcd = {bcd_adj[itf_pkg::BCD_W-2:0], r_bin[itf_pkg::NUM_W-1]};
                n_bin = r_bin << 1;
                if (r_cnt == '0) begin
                    n_cnt   = 6'(itf_pkg::DEC_DIGITS - 1);
                    n_seen  = 1'b0;
                    n_state = S_DEC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DEC: begin
                n_bcd = r_bcd << 4;
                // drop leading zeros, but always write the units digit
                if (top_digit != 4'd0 || r_seen || r_cnt == '0) begin
                    n_strobe = 1'b1;
                    n_seen   = 1'b1;
                    n_char   = itf_pkg::CH_ZERO | {3'b000, top_digit};
                    n_last   = (r_cnt == '0);
                end
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_HEX: begin
                n_strobe = 1'b1;
                n_char   = itf_pkg::hex_char(r_bin[itf_pkg::NUM_W-1 -: 4]);
                n_last   = (r_cnt == '0);
                n_bin    = r_bin << 4;
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_seen <= n_seen;
        r_char <= n_char;
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_dabble_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DABBLE && r_cnt == '0) |=> (r_state == S_DEC))
        else $error("binary to BCD pass did not end in the digit scan");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (r_state == S_IDLE))
        else $error("final character shown while a job is still running");

    a_sign_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DABBLE && r_strobe) |->
        (r_cnt == 6'd63 && r_char == itf_pkg::CH_MINUS && !r_last))
        else $error("unexpected character during binary to BCD pass");

    a_pop_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && i_job_valid))
        else $error("job taken while busy or queue empty");

endmodule

// ===== hdl/integer_to_text_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_text_formatter: 64-bit integer to ASCII text
// Writes a number as signed decimal, unsigned decimal, magnitude-sized hex
// or 16-digit hex, one character per result beat.
// ----------------------------------------------------------------------------
// Raise start with i_operation and i_number while busy is low to hand in a
// number; busy stays high only while the job queue (QUEUE_DEPTH entries) is
// full. Characters leave on o_character with o_strobe high for one cycle
// each, and o_last marks the final character of a number; there is no
// backpressure, so capture every strobed beat. The back end works one number
// at a time. A hex number is loaded, then its digits are written from the
// top. A decimal number is loaded, passed through the bit-serial binary to
// BCD converter, and then a scan over the BCD digits drops leading zeros;
// a minus sign is written during the first converter cycle. The converter
// loop sets the sustained rate for decimal text.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
    parameter int QUEUE_DEPTH = itf_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [itf_pkg::OP_W-1:0]   i_operation,
    input  logic [itf_pkg::NUM_W-1:0]  i_number,
    output logic                       o_strobe,
    output logic [itf_pkg::CHAR_W-1:0] o_character,
    output logic                       o_last
);

    itf_pkg::t_job front_job;   // classified beat from the front end
    itf_pkg::t_job head_job;    // oldest queued job
    logic          q_full;
    logic          q_valid;
    logic          pop;
    logic          push;

    // Accept a beat whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

    // Front end: decode selector, take magnitude, size hex output
    itf_front u_front (
        .i_operation (i_operation),
        .i_number    (i_number),
        .o_job       (front_job)
    );

    // Hold classified jobs until the back end is free
    itf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back end: convert and stream characters
    itf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_text_formatter
// Hands numbers to the formatter through the start/busy command port and
// predicts the ASCII text of each one. A monitor compares every strobed
// character beat with the oldest predicted beat. Directed corner values come
// first, then random numbers with idle bursts, then back-to-back numbers.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_W      = itf_pkg::NUM_W;
    localparam int OP_W       = itf_pkg::OP_W;
    localparam int CHAR_W     = itf_pkg::CHAR_W;
    localparam int DEC_DIGITS = itf_pkg::DEC_DIGITS;

    // Decimal text takes the longest: load, binary to BCD pass, digit scan.
    localparam int DEC_CYCLES    = 85;
    localparam int SETTLE_CYCLES = DEC_CYCLES + 15;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT     = 1000000;

    localparam int MIX_ITEMS     = 200;
    localparam int BURST_ITEMS   = 70;

    localparam logic [NUM_W-1:0] ALL_ONES = {NUM_W{1'b1}};
    localparam logic [NUM_W-1:0] MOST_NEG = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [NUM_W-1:0] MOST_POS = {1'b0, {(NUM_W-1){1'b1}}};

    // One character beat of predicted text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_operation;
    logic [NUM_W-1:0]  i_number;
    logic              o_strobe;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;

    t_text_beat pending_text[$];   // predicted beats, oldest first
    int         fail_count = 0;
    bit         gaps_on    = 1'b0; // allow idle bursts between numbers

    integer_to_text_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_number    (i_number),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the text of one number and queue its beats in order.
    function automatic void predict_text(input itf_pkg::t_op op,
                                         input logic [NUM_W-1:0] num);
        logic [NUM_W-1:0]  mag;
        logic [3:0]        dec_digit [DEC_DIGITS];
        logic [3:0]        nib;
        logic [CHAR_W-1:0] ch;
        int                n_dec;
        int                n_hex;
        int                i;
        t_text_beat        beat;

        if (op == itf_pkg::OP_SDEC || op == itf_pkg::OP_UDEC) begin
            mag = num;
            // Negative signed values: emit the sign, then the magnitude.
            // The most negative value wraps to itself, which is 2^63 unsigned.
            if (op == itf_pkg::OP_SDEC && num[NUM_W-1]) begin
                mag = ~num + 1'b1;
                beat.ch   = itf_pkg::CH_MINUS;
                beat.last = 1'b0;
                pending_text.push_back(beat);
            end
            // Peel digits least significant first; zero still yields one digit.
            n_dec = 0;
            do begin
                dec_digit[n_dec] = 4'(mag % 10);
                mag = mag / 10;
                n_dec++;
            end while (mag != 0);
            for (i = n_dec - 1; i >= 0; i--) begin
                beat.ch   = itf_pkg::CH_ZERO + CHAR_W'(dec_digit[i]);
                beat.last = (i == 0);
                pending_text.push_back(beat);
            end
        end else begin
            // Pick the digit count: fixed 16, or the smallest size that fits.
            if (op == itf_pkg::OP_HEX_16) n_hex = 16;
            else if (num <= 64'hFF)       n_hex = 2;
            else if (num <= 64'hFFFF)     n_hex = 4;
            else if (num <= 64'hFFFFFFFF) n_hex = 8;
            else                          n_hex = 16;
            for (i = 0; i < n_hex; i++) begin
                nib = 4'(num >> (4 * (n_hex - 1 - i)));
                ch  = {3'b000, nib};
                beat.ch   = (nib > 4'd9) ? ch + itf_pkg::HEX_ALPHA_OF
                                         : ch + itf_pkg::CH_ZERO;
                beat.last = (i == n_hex - 1);
                pending_text.push_back(beat);
            end
        end
    endfunction

    // Draw a number that lands on the interesting spots more often than
    // a flat draw would: decade edges, hex size edges, sign edges, tiny values.
    function automatic logic [NUM_W-1:0] pick_number();
        logic [NUM_W-1:0] val;
        int               k;

        case ($urandom_range(0, 5))
            0: val = {$urandom, $urandom};
            1: val = {$urandom, $urandom} >> $urandom_range(0, NUM_W - 1);
            2: begin
                val = NUM_W'(1);
                k   = $urandom_range(0, DEC_DIGITS - 1);
                repeat (k) val = val * 10;
                val = val + NUM_W'($urandom_range(0, 2)) - 1;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0:       val = 64'hFF;
                    1:       val = 64'hFFFF;
                    2:       val = 64'hFFFFFFFF;
                    3:       val = MOST_POS;
                    default: val = ALL_ONES;
                endcase
                val = val + NUM_W'($urandom_range(0, 2)) - 1;
            end
            4: val = NUM_W'($urandom_range(0, 20));
            default: val = -NUM_W'($urandom_range(1, 1000));
        endcase
        return val;
    endfunction

    // Hand in one number; hold start high until the formatter takes it.
    // Start stays high on return so the next beat can follow without a gap.
    task automatic send_number(input itf_pkg::t_op op, input logic [NUM_W-1:0] num);
        int idle_len;

        if (gaps_on && $urandom_range(0, 3) == 0) begin
            idle_len = $urandom_range(1, 8);
            @(negedge i_clk);
            start       <= 1'b0;
            i_operation <= OP_W'($urandom);
            i_number    <= {$urandom, $urandom};
            repeat (idle_len) @(posedge i_clk);
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_number    <= num;
        do @(posedge i_clk); while (busy);
        predict_text(op, num);
    endtask

    // Drop start and wait until every predicted beat has come out,
    // then give the back end time to show any stray beat.
    task automatic wait_text_drained();
        int waited;

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_text.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_signed_decimal();
        send_number(itf_pkg::OP_SDEC, 64'd0);
        send_number(itf_pkg::OP_SDEC, 64'd1);
        send_number(itf_pkg::OP_SDEC, ALL_ONES);           // -1
        send_number(itf_pkg::OP_SDEC, 64'd10);
        send_number(itf_pkg::OP_SDEC, -64'd10);
        send_number(itf_pkg::OP_SDEC, MOST_POS);
        send_number(itf_pkg::OP_SDEC, MOST_NEG);           // longest text, 20 beats
    endtask

    task automatic test_unsigned_decimal();
        send_number(itf_pkg::OP_UDEC, 64'd0);
        send_number(itf_pkg::OP_UDEC, 64'd9);
        send_number(itf_pkg::OP_UDEC, 64'd9999999999999999999);
        send_number(itf_pkg::OP_UDEC, 64'd10000000000000000000);
        send_number(itf_pkg::OP_UDEC, ALL_ONES);
    endtask

    task automatic test_hex_by_magnitude();
        send_number(itf_pkg::OP_HEX_MAG, 64'h0);
        send_number(itf_pkg::OP_HEX_MAG, 64'hFF);
        send_number(itf_pkg::OP_HEX_MAG, 64'h100);
        send_number(itf_pkg::OP_HEX_MAG, 64'hFFFF);
        send_number(itf_pkg::OP_HEX_MAG, 64'h10000);
        send_number(itf_pkg::OP_HEX_MAG, 64'hFFFFFFFF);
        send_number(itf_pkg::OP_HEX_MAG, 64'h1_0000_0000);
        send_number(itf_pkg::OP_HEX_MAG, ALL_ONES);
    endtask

    task automatic test_hex_16();
        send_number(itf_pkg::OP_HEX_16, 64'h0);
        send_number(itf_pkg::OP_HEX_16, 64'h0123456789ABCDEF);
        send_number(itf_pkg::OP_HEX_16, 64'hFEDCBA9876543210);
        send_number(itf_pkg::OP_HEX_16, ALL_ONES);
    endtask

    // Random numbers and selectors; switch idle bursts on and off in
    // stretches so gaps land on every phase of a conversion.
    task automatic test_random_mix();
        for (int n = 0; n < MIX_ITEMS; n++) begin
            if (n % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n == MIX_ITEMS / 2) wait_text_drained();   // pause on an empty pipe
            send_number(itf_pkg::t_op'($urandom_range(0, 3)), pick_number());
        end
        gaps_on = 1'b0;
    endtask

    // Last stretch: no idle cycles, keep the job queue full.
    task automatic test_random_back_to_back();
        gaps_on = 1'b0;
        for (int n = 0; n < BURST_ITEMS; n++) begin
            send_number(itf_pkg::t_op'($urandom_range(0, 3)), pick_number());
        end
    endtask

    // Compare each strobed beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n && o_strobe) begin
            if (pending_text.size() == 0) begin
                $error("unexpected beat: character %h last %b", o_character, o_last);
                fail_count++;
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.ch) begin
                    $error("character: expected %h, got %h", want.ch, o_character);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = itf_pkg::OP_SDEC;
        i_number    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_signed_decimal();
        test_unsigned_decimal();
        test_hex_by_magnitude();
        test_hex_16();
        wait_text_drained();
        test_random_mix();
        test_random_back_to_back();
        wait_text_drained();

        if (pending_text.size() != 0) begin
            $error("%0d predicted beats never came out", pending_text.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS integer_to_text_formatter");
        end else begin
            $display("FAIL integer_to_text_formatter");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #(2 * RUN_LIMIT);
        $display("FAIL integer_to_text_formatter");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/itf_pkg.sv
hdl/itf_front.sv
hdl/itf_queue.sv
hdl/itf_back.sv
hdl/integer_to_text_formatter.sv
tb/sv/tb.sv
